### src/fspa_pkg.sv
// Package for the fixed-slot pool allocator.
// Holds field widths, register indexes, request and status codes and reset values.
// Used by fixed_slot_pool_allocator_core; depends on nothing.
package fspa_pkg;

    localparam int REQ_W  = 2;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;
    localparam int STAT_W = 2;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam int SLOT_COUNT_DEF = 1024;

    localparam logic [CNT_W-1:0] MIN_SLOTS_RST = 11'd16;
    localparam logic [CNT_W-1:0] MAX_SLOTS_RST = 11'd1024;
    localparam logic [CNT_W-1:0] GROW_STEP_RST = 11'd64;

    localparam logic [1:0] REG_MIN_SLOTS = 2'd0;
    localparam logic [1:0] REG_MAX_SLOTS = 2'd1;
    localparam logic [1:0] REG_GROW_STEP = 2'd2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_RESET = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NONE_USED = 2'd2,
        ST_BAD_CFG   = 2'd3
    } t_status;

endpackage

### src/fixed_slot_pool_allocator_core.sv
// Fixed-slot pool allocator core with a LIFO free-slot stack in block memory.
// Depends on fspa_pkg for widths, codes and configuration reset values.
//
// Channel   Direction  Handshake                      Payload
// request   in         start && !busy                 i_req_type, i_slot
// result    out        o_done (one cycle, no stall)   o_status, o_granted_slot,
//                                                     o_in_use_count, o_current_limit
// config    in         psel && penable && pwrite      paddr, pwdata (prdata on read)
//
// A request is accepted whenever busy is low and its result appears in the next
// cycle, so one request per cycle is sustained. The result is registered to match
// the registered read of the stack memory that a reusing allocation needs. Each
// request writes the stack at its own accept edge, so the next request always reads
// settled contents. busy is set by reset and clears after it. Reset is synchronous;
// it clears the counters and loads the reset limit and config; stack memory is kept.
module fixed_slot_pool_allocator_core #(
    parameter int SLOT_COUNT = fspa_pkg::SLOT_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fspa_pkg::REQ_W-1:0]   i_req_type,
    input  logic [fspa_pkg::SLOT_W-1:0]  i_slot,
    output logic                         o_done,
    output logic [fspa_pkg::STAT_W-1:0]  o_status,
    output logic [fspa_pkg::SLOT_W-1:0]  o_granted_slot,
    output logic [fspa_pkg::CNT_W-1:0]   o_in_use_count,
    output logic [fspa_pkg::CNT_W-1:0]   o_current_limit,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fspa_pkg::ADDR_W-1:0]  paddr,
    input  logic [fspa_pkg::DATA_W-1:0]  pwdata,
    output logic [fspa_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import fspa_pkg::*;

    localparam int AW = $clog2(SLOT_COUNT);

    logic [CNT_W-1:0]  r_min_slots;
    logic [CNT_W-1:0]  r_max_slots;
    logic [CNT_W-1:0]  r_grow_step;
    logic [CNT_W-1:0]  r_in_use;
    logic [CNT_W-1:0]  r_fresh_mark;
    logic [CNT_W-1:0]  r_limit;
    logic              r_busy;
    logic              r_done;
    logic              r_pop;
    t_status           r_status;
    logic [SLOT_W-1:0] r_granted;
    logic [SLOT_W-1:0] r_rdata;

    logic [CNT_W-1:0]  n_in_use;
    logic [CNT_W-1:0]  n_fresh_mark;
    logic [CNT_W-1:0]  n_limit;
    logic              n_pop;
    t_status           n_status;
    logic [SLOT_W-1:0] n_granted;

    logic [SLOT_W-1:0] mem [SLOT_COUNT];

    logic              accept;
    logic              cfg_write;
    logic              cfg_bad;
    logic              fresh_full;
    logic              grows;
    logic [CNT_W-1:0]  depth;
    logic [CNT_W-1:0]  grow_room;
    logic [CNT_W-1:0]  grow_base;
    logic [CNT_W-1:0]  grow_diff;
    logic [CNT_W-1:0]  grown_limit;
    logic              mem_we;
    logic [AW+CNT_W-1:0] rd_ext;
    logic [AW+CNT_W-1:0] wr_ext;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign busy      = r_busy;

    assign cfg_bad = (r_min_slots == '0) || (r_grow_step == '0) ||
                     (r_min_slots > r_max_slots) || (32'(r_max_slots) > SLOT_COUNT);
    assign fresh_full = 32'(r_fresh_mark) >= SLOT_COUNT;

    assign depth       = r_fresh_mark - r_in_use;
    assign grow_room   = r_max_slots - r_limit;
    assign grow_base   = (r_limit <= r_grow_step) ? r_limit : r_grow_step;
    assign grow_diff   = (grow_base > grow_room) ? grow_room : grow_base;
    assign grows       = (r_limit < r_max_slots) && (grow_diff != '0);
    assign grown_limit = r_limit + grow_diff;

    assign rd_ext = {{AW{1'b0}}, depth - 11'd1};
    assign wr_ext = {{AW{1'b0}}, depth};

    always_comb begin
        n_in_use     = r_in_use;
        n_fresh_mark = r_fresh_mark;
        n_limit      = r_limit;
        n_status     = ST_OK;
        n_granted    = '0;
        n_pop        = 1'b0;
        mem_we       = 1'b0;
        if (accept) begin
            if (cfg_bad) begin
                n_status = ST_BAD_CFG;
            end else begin
                case (t_req'(i_req_type))
                    REQ_ALLOC: begin
                        if ((r_in_use > r_limit) || ((r_in_use == r_limit) && !grows)) begin
                            n_status = ST_EXHAUSTED;
                        end else begin
                            if (r_in_use == r_limit) begin
                                n_limit = grown_limit;
                            end
                            if (r_in_use == r_fresh_mark) begin
                                if (fresh_full) begin
                                    n_status = ST_EXHAUSTED;
                                end else begin
                                    n_granted    = r_fresh_mark[SLOT_W-1:0];
                                    n_fresh_mark = r_fresh_mark + 11'd1;
                                    n_in_use     = r_in_use + 11'd1;
                                end
                            end else begin
                                n_pop    = 1'b1;
                                n_in_use = r_in_use + 11'd1;
                            end
                        end
                    end
                    REQ_FREE: begin
                        if (r_in_use == '0) begin
                            n_status = ST_NONE_USED;
                        end else begin
                            mem_we   = 1'b1;
                            n_in_use = r_in_use - 11'd1;
                        end
                    end
                    REQ_RESET: begin
                        n_limit      = r_min_slots;
                        n_fresh_mark = '0;
                        n_in_use     = '0;
                    end
                    REQ_QUERY: begin
                        n_status = ST_OK;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_ext[AW-1:0]] <= i_slot;
        end
        if (n_pop) begin
            r_rdata <= mem[rd_ext[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_fresh_mark <= '0;
            r_limit      <= MIN_SLOTS_RST;
            r_busy       <= 1'b1;
            r_done       <= 1'b0;
            r_pop        <= 1'b0;
        end else begin
            r_in_use     <= n_in_use;
            r_fresh_mark <= n_fresh_mark;
            r_limit      <= n_limit;
            r_busy       <= 1'b0;
            r_done       <= accept;
            r_pop        <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_granted <= n_granted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_slots <= MIN_SLOTS_RST;
            r_max_slots <= MAX_SLOTS_RST;
            r_grow_step <= GROW_STEP_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_MIN_SLOTS: r_min_slots <= pwdata[CNT_W-1:0];
                REG_MAX_SLOTS: r_max_slots <= pwdata[CNT_W-1:0];
                REG_GROW_STEP: r_grow_step <= pwdata[CNT_W-1:0];
                default: begin
                    r_min_slots <= r_min_slots;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MIN_SLOTS: prdata = {{(DATA_W-CNT_W){1'b0}}, r_min_slots};
            REG_MAX_SLOTS: prdata = {{(DATA_W-CNT_W){1'b0}}, r_max_slots};
            REG_GROW_STEP: prdata = {{(DATA_W-CNT_W){1'b0}}, r_grow_step};
            default:       prdata = '0;
        endcase
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_slot  = r_pop ? r_rdata : r_granted;
    assign o_in_use_count  = r_in_use;
    assign o_current_limit = r_limit;

`ifndef ASSERT_OFF
    a_in_use_le_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= r_fresh_mark)
        else $error("In-use count exceeds the fresh mark.");

    a_in_use_le_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_use <= r_limit)
        else $error("In-use count exceeds the slot limit.");

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("Accepted request produced no result.");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_done)
        else $error("Result strobe without an accepted request.");

    a_alloc_ok_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req_type == REQ_ALLOC)) |=>
            ((o_status != ST_OK) || (r_in_use == $past(r_in_use) + 11'd1)))
        else $error("Successful allocation did not raise the in-use count.");
`endif

endmodule
